// ----- sv/laqs_pkg.sv -----
// Package for the linear array queue with search unit.
// Holds operation and status codes plus field widths; no dependencies.
package laqs_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int QSIZE_W       = 7;
    localparam int TDATA_OUT_W   = 40;
    localparam int TUSER_W       = 2;

    localparam logic [QSIZE_W-1:0] QSIZE_RESET = QSIZE_W'(64);

    typedef enum logic [1:0] {
        OP_PUSH     = 2'd0,
        OP_POP      = 2'd1,
        OP_TRAVERSE = 2'd2,
        OP_SEARCH   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

// ----- sv/linear_array_queue_with_search_unit.sv -----
// Top level of the linear array queue with search unit.
// Depends on laqs_pkg; holds the slot memory, control FSM and output register.
//
// channel | dir | handshake        | payload
// s_*     | in  | tvalid / tready  | tuser: operation, tdata: value
// m_*     | out | tvalid / tready  | tuser: status, tdata: data, match_count; tlast
// cfg_*   | in  | wr_en            | wr_data: queue_size
//
// Push, and any operation on an empty queue, answer straight from idle; pop answers from S_POP after a memory read.
// Traverse of n entries does one memory read and yields one item per cycle while m_tready does not stall.
// Search of n entries compares one slot per cycle, then loads the match count from S_DONE.
// One item is worked at a time; the next is taken when the last result is loaded.
// A stalled m_tready holds a traverse walk and the final search result; reset needs no clearing pass.
module linear_array_queue_with_search_unit
    import laqs_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [WORD_W-1:0]      s_tdata,     // [31:0] value
    input  logic [TUSER_W-1:0]     s_tuser,     // [1:0] operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,     // [31:0] data, [38:32] match_count, [39] zero
    output logic [TUSER_W-1:0]     m_tuser,     // [1:0] status
    output logic                   m_tlast,
    input  logic                   cfg_wr_en,
    input  logic [QSIZE_W-1:0]     cfg_wr_data
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [QSIZE_W-1:0]  qsize_reg;
    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [PTR_W-1:0]    cur_reg, cur_next;
    logic [PTR_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   key_reg, key_next;
    logic                search_reg, search_next;

    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [WORD_W-1:0]   m_data_reg, m_data_next;
    logic [QSIZE_W-1:0]  m_count_reg, m_count_next;
    logic                m_last_reg, m_last_next;

    logic [WORD_W-1:0]   mem [DEPTH];
    logic [WORD_W-1:0]   rd_data_reg;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;

    logic                out_free;
    logic                s_fire;
    logic                empty;
    logic                full;
    logic [PTR_W-1:0]    cur_inc;
    logic                cur_last;
    logic                rd_hit;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign empty    = head_reg == tail_reg;
    assign full     = (QSIZE_W'(tail_reg) >= qsize_reg) || (tail_reg == PTR_W'(DEPTH));
    assign cur_inc  = cur_reg + PTR_W'(1);
    assign cur_last = cur_inc == tail_reg;
    assign rd_hit   = rd_data_reg == key_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_data_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tail_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        cur_next      = cur_reg;
        count_next    = count_reg;
        key_next      = key_reg;
        search_next   = search_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        m_count_next  = m_count_reg;
        m_last_next   = m_last_reg;
        wr_en         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = head_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    m_data_next  = '0;
                    m_count_next = '0;
                    m_last_next  = 1'b1;
                    if (empty && (op_t'(s_tuser) != OP_PUSH))
                    begin
                        m_valid_next  = 1'b1;
                        m_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        unique case (op_t'(s_tuser))
                            OP_PUSH:
                            begin
                                m_valid_next = 1'b1;
                                if (full)
                                begin
                                    m_status_next = ST_FULL;
                                end
                                else
                                begin
                                    m_status_next = ST_OK;
                                    wr_en         = 1'b1;
                                    tail_next     = tail_reg + PTR_W'(1);
                                end
                            end
                            OP_POP:
                            begin
                                rd_en      = 1'b1;
                                head_next  = head_reg + PTR_W'(1);
                                state_next = S_POP;
                            end
                            OP_TRAVERSE:
                            begin
                                rd_en       = 1'b1;
                                cur_next    = head_reg;
                                search_next = 1'b0;
                                state_next  = S_WALK;
                            end
                            OP_SEARCH:
                            begin
                                rd_en       = 1'b1;
                                cur_next    = head_reg;
                                key_next    = s_tdata;
                                count_next  = '0;
                                search_next = 1'b1;
                                state_next  = S_WALK;
                            end
                        endcase
                    end
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_data_next   = rd_data_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (search_reg)
                begin
                    count_next = count_reg + PTR_W'(rd_hit);
                    if (cur_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_inc[ADDR_W-1:0];
                        cur_next = cur_inc;
                    end
                end
                else if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_data_next   = rd_data_reg;
                    m_last_next   = cur_last;
                    if (cur_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = cur_inc[ADDR_W-1:0];
                        cur_next = cur_inc;
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_OK;
                    m_data_next   = '0;
                    m_count_next  = QSIZE_W'(count_reg);
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            qsize_reg    <= QSIZE_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            m_valid_reg  <= 1'b0;
            cur_reg      <= '0;
            count_reg    <= '0;
            search_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_wr_en)
            begin
                qsize_reg <= cfg_wr_data;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            m_valid_reg  <= m_valid_next;
            cur_reg      <= cur_next;
            count_reg    <= count_next;
            search_reg   <= search_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_count_reg  <= m_count_next;
        m_last_reg   <= m_last_next;
    end

`ifndef SYNTHESIS
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= tail_reg)
        else $error("head passed tail");

    a_tail_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= PTR_W'(DEPTH))
        else $error("tail beyond depth");

    a_push_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (op_t'(s_tuser) == OP_PUSH) && !full)
        |=> (tail_reg == $past(tail_reg) + PTR_W'(1)))
        else $error("accepted push did not advance tail");

    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (cur_reg >= head_reg && cur_reg < tail_reg))
        else $error("walk pointer out of range");
`endif

endmodule
